### hdl/dwsl_pkg.sv
`timescale 1ns / 1ps
// shared types, codes and constants of the dual wheel speed loop
// no dependencies

package dwsl_pkg;

    // command codes
    localparam logic [1:0] CMD_LEFT_PULSE  = 2'd0;
    localparam logic [1:0] CMD_RIGHT_PULSE = 2'd1;
    localparam logic [1:0] CMD_TICK        = 2'd2;

    // configuration register indexes
    localparam logic [1:0] CFG_TUNING_ENABLED   = 2'd0;
    localparam logic [1:0] CFG_SLOW_COUNT_LIMIT = 2'd1;
    localparam logic [1:0] CFG_MAX_CORRECTION   = 2'd2;

    // configuration reset values
    localparam logic       TUNING_RESET     = 1'b0;
    localparam logic [7:0] SLOW_LIMIT_RESET = 8'd255;
    localparam logic [6:0] MAX_CORR_RESET   = 7'd10;

    // control law constants
    localparam logic [6:0]  SLOW_TARGET_MIN   = 7'd15;
    localparam logic [15:0] SLOW_PULSE_LIMIT  = 16'd15;
    localparam logic [6:0]  MIN_ACTIVE_TARGET = 7'd1;
    localparam logic [6:0]  DUTY_MAX          = 7'd100;
    localparam logic [15:0] PULSE_SAT         = 16'hFFFF;

    // floor(x / 5) as (x * 205) >> 10, exact for x below 1024
    localparam logic [7:0] RECIP_5       = 8'd205;
    localparam int         RECIP_5_SHIFT = 10;

    typedef struct packed {
        logic       pulse;
        logic       tick;
        logic       forward;
        logic       brake;
        logic [6:0] target;
    } t_wheel_cmd;

    typedef struct packed {
        logic [7:0] slow_limit;
        logic [6:0] max_corr;
    } t_loop_cfg;

    typedef struct packed {
        logic [6:0]  duty;
        logic [7:0]  slow;
        logic [7:0]  speed;
        logic [31:0] position;
        logic [31:0] steps;
    } t_wheel_state;

    // floor(3 * target / 5) without a divider
    function automatic logic [6:0] slow_threshold(input logic [6:0] target);
        logic [8:0]  triple;
        logic [16:0] prod;
        triple = {1'b0, target, 1'b0} + {2'b00, target};
        prod   = {8'd0, triple} * {9'd0, RECIP_5};
        return prod[RECIP_5_SHIFT +: 7];
    endfunction

endpackage

### hdl/dual_wheel_speed_loop.sv
`timescale 1ns / 1ps
// dual wheel speed loop: an accepted item passes the input register and then the result register before o_valid
// rises; throughput one item per cycle while i_ready is held high
// each item gives one result holding both wheels' state after that item
// synchronous active-low reset clears all counters, duties and positions,
// and loads tuning off, slow count limit 255, max correction 10
// depends on dwsl_pkg and dwsl_wheel

module dual_wheel_speed_loop
    import dwsl_pkg::*;
(
    input  logic               i_clk,
    input  logic               i_rst_n,
    // configuration write port
    input  logic               i_cfg_we,
    input  logic [1:0]         i_cfg_index,
    input  logic [7:0]         i_cfg_data,
    // input channel
    input  logic               i_valid,
    output logic               o_ready,
    input  logic [1:0]         i_command,
    input  logic               i_forward,
    input  logic [6:0]         i_left_target,
    input  logic [6:0]         i_right_target,
    input  logic               i_brake,
    // result channel
    output logic               o_valid,
    input  logic               i_ready,
    output logic [6:0]         o_left_duty,
    output logic [6:0]         o_right_duty,
    output logic [7:0]         o_left_slow_count,
    output logic [7:0]         o_right_slow_count,
    output logic [7:0]         o_left_measured_speed,
    output logic [7:0]         o_right_measured_speed,
    output logic signed [31:0] o_left_position,
    output logic signed [31:0] o_right_position,
    output logic [31:0]        o_left_total_steps,
    output logic [31:0]        o_right_total_steps
);

    // configuration registers
    logic       r_tuning;
    logic [7:0] r_slow_limit;
    logic [6:0] r_max_corr;

    // input register stage
    logic       r_in_valid;
    logic [1:0] r_in_command;
    logic       r_in_forward;
    logic [6:0] r_in_left_target;
    logic [6:0] r_in_right_target;
    logic       r_in_brake;

    // result register stage
    logic         r_out_valid;
    t_wheel_state r_out_left;
    t_wheel_state r_out_right;

    logic         w_advance;
    logic         w_tick;
    t_loop_cfg    w_cfg;
    t_wheel_cmd   w_left_cmd;
    t_wheel_cmd   w_right_cmd;
    t_wheel_state w_left_next;
    t_wheel_state w_right_next;

    // the held item moves on when the result register is empty or being drained
    assign w_advance = r_in_valid && (!r_out_valid || i_ready);
    // the input register takes a new transfer whenever it is empty or empties in the same cycle
    assign o_ready   = !r_in_valid || w_advance;

    // ticks act only while tuning is enabled; command 3 touches nothing
    assign w_tick = (r_in_command == CMD_TICK) && r_tuning;
    assign w_cfg  = '{slow_limit: r_slow_limit, max_corr: r_max_corr};

    assign w_left_cmd = '{pulse: (r_in_command == CMD_LEFT_PULSE), tick: w_tick,
                          forward: r_in_forward, brake: r_in_brake,
                          target: r_in_left_target};
    assign w_right_cmd = '{pulse: (r_in_command == CMD_RIGHT_PULSE), tick: w_tick,
                           forward: r_in_forward, brake: r_in_brake,
                           target: r_in_right_target};

    always_ff @(posedge i_clk) begin
        if (!i_rst_n) begin
            r_tuning     <= TUNING_RESET;
            r_slow_limit <= SLOW_LIMIT_RESET;
            r_max_corr   <= MAX_CORR_RESET;
        end else if (i_cfg_we) begin
            case (i_cfg_index)
                CFG_TUNING_ENABLED:   r_tuning     <= i_cfg_data[0];
                CFG_SLOW_COUNT_LIMIT: r_slow_limit <= i_cfg_data;
                CFG_MAX_CORRECTION:   r_max_corr   <= i_cfg_data[6:0];
                default: ;
            endcase
        end
    end

    // input register: control bit reset, payload loaded on each transfer
    always_ff @(posedge i_clk) begin
        if (!i_rst_n) begin
            r_in_valid <= 1'b0;
        end else if (o_ready) begin
            r_in_valid <= i_valid;
        end
    end

    always_ff @(posedge i_clk) begin
        if (i_valid && o_ready) begin
            r_in_command      <= i_command;
            r_in_forward      <= i_forward;
            r_in_left_target  <= i_left_target;
            r_in_right_target <= i_right_target;
            r_in_brake        <= i_brake;
        end
    end

    dwsl_wheel u_left (
        .i_clk    (i_clk),
        .i_rst_n  (i_rst_n),
        .i_commit (w_advance),
        .i_cmd    (w_left_cmd),
        .i_cfg    (w_cfg),
        .o_next   (w_left_next)
    );

    dwsl_wheel u_right (
        .i_clk    (i_clk),
        .i_rst_n  (i_rst_n),
        .i_commit (w_advance),
        .i_cmd    (w_right_cmd),
        .i_cfg    (w_cfg),
        .o_next   (w_right_next)
    );

    // result register: snapshot of both wheels after the committed item
    always_ff @(posedge i_clk) begin
        if (!i_rst_n) begin
            r_out_valid <= 1'b0;
        end else if (w_advance) begin
            r_out_valid <= 1'b1;
        end else if (i_ready) begin
            r_out_valid <= 1'b0;
        end
    end

    always_ff @(posedge i_clk) begin
        if (w_advance) begin
            r_out_left  <= w_left_next;
            r_out_right <= w_right_next;
        end
    end

    assign o_valid                = r_out_valid;
    assign o_left_duty            = r_out_left.duty;
    assign o_right_duty           = r_out_right.duty;
    assign o_left_slow_count      = r_out_left.slow;
    assign o_right_slow_count     = r_out_right.slow;
    assign o_left_measured_speed  = r_out_left.speed;
    assign o_right_measured_speed = r_out_right.speed;
    assign o_left_position        = $signed(r_out_left.position);
    assign o_right_position       = $signed(r_out_right.position);
    assign o_left_total_steps     = r_out_left.steps;
    assign o_right_total_steps    = r_out_right.steps;

    a_commit_fills_result: assert property (@(posedge i_clk) disable iff (!i_rst_n)
        w_advance |=> r_out_valid)
        else $error("committed item left no result");

    a_stall_holds_item: assert property (@(posedge i_clk) disable iff (!i_rst_n)
        r_out_valid && !i_ready |-> !w_advance)
        else $error("item committed while result stalled");

    a_brake_zeroes: assert property (@(posedge i_clk) disable iff (!i_rst_n)
        w_advance && w_tick && r_in_brake |=>
            r_out_left.duty == 7'd0 && r_out_right.duty == 7'd0)
        else $error("brake tick left a nonzero duty");

endmodule

### hdl/dwsl_wheel.sv
`timescale 1ns / 1ps
// one wheel: pulse counting, position, step count and the per tick duty, slow count and speed update
// depends on dwsl_pkg

module dwsl_wheel
    import dwsl_pkg::*;
(
    input  logic         i_clk,
    input  logic         i_rst_n,
    input  logic         i_commit,
    input  t_wheel_cmd   i_cmd,
    input  t_loop_cfg    i_cfg,
    output t_wheel_state o_next
);

    logic [15:0] r_pulses, n_pulses;
    logic [6:0]  r_duty, n_duty;
    logic [7:0]  r_slow, n_slow;
    logic [7:0]  r_speed, n_speed;
    logic [31:0] r_position, n_position;
    logic [31:0] r_steps, n_steps;

    logic [6:0]         w_thresh;
    logic               w_is_slow;
    logic [8:0]         w_slow_inc;
    logic signed [17:0] w_err;
    logic signed [17:0] w_err_capped;
    logic signed [18:0] w_duty_sum;

    assign w_thresh   = slow_threshold(i_cmd.target);
    assign w_is_slow  = (i_cmd.target > SLOW_TARGET_MIN) && (r_pulses < SLOW_PULSE_LIMIT)
                        && (r_pulses < {9'd0, w_thresh});
    assign w_slow_inc = {1'b0, r_slow} + 9'd1;

    assign w_err = $signed({11'd0, i_cmd.target}) - $signed({2'b00, r_pulses});
    assign w_err_capped = (w_err > $signed({11'd0, i_cfg.max_corr}))
                          ? $signed({11'd0, i_cfg.max_corr}) : w_err;
    assign w_duty_sum = $signed({12'd0, r_duty}) + {w_err_capped[17], w_err_capped};

    always_comb begin
        n_pulses   = r_pulses;
        n_duty     = r_duty;
        n_slow     = r_slow;
        n_speed    = r_speed;
        n_position = r_position;
        n_steps    = r_steps;
        if (i_cmd.pulse) begin
            if (r_pulses != PULSE_SAT) begin
                n_pulses = r_pulses + 16'd1;
            end
            n_steps = r_steps + 32'd1;
            if (i_cmd.forward) begin
                n_position = r_position + 32'd1;
            end else begin
                n_position = r_position - 32'd1;
            end
        end else if (i_cmd.tick) begin
            if (w_is_slow) begin
                n_slow = (w_slow_inc > {1'b0, i_cfg.slow_limit}) ? i_cfg.slow_limit
                                                                : w_slow_inc[7:0];
            end else begin
                n_slow = 8'd0;
            end
            if (i_cmd.target > MIN_ACTIVE_TARGET) begin
                n_speed = r_pulses[7:0];
                if (w_duty_sum < 0) begin
                    n_duty = 7'd0;
                end else if (w_duty_sum > $signed({12'd0, DUTY_MAX})) begin
                    n_duty = DUTY_MAX;
                end else begin
                    n_duty = w_duty_sum[6:0];
                end
            end else begin
                n_duty = 7'd0;
            end
            if (i_cmd.brake) begin
                n_duty = 7'd0;
            end
            n_pulses = 16'd0;
        end
    end

    always_ff @(posedge i_clk) begin
        if (!i_rst_n) begin
            r_pulses   <= 16'd0;
            r_duty     <= 7'd0;
            r_slow     <= 8'd0;
            r_speed    <= 8'd0;
            r_position <= 32'd0;
            r_steps    <= 32'd0;
        end else if (i_commit) begin
            r_pulses   <= n_pulses;
            r_duty     <= n_duty;
            r_slow     <= n_slow;
            r_speed    <= n_speed;
            r_position <= n_position;
            r_steps    <= n_steps;
        end
    end

    assign o_next = '{duty: n_duty, slow: n_slow, speed: n_speed,
                      position: n_position, steps: n_steps};

    a_steps_count: assert property (@(posedge i_clk) disable iff (!i_rst_n)
        i_commit && i_cmd.pulse |=> r_steps == $past(r_steps) + 32'd1)
        else $error("step count did not advance on a pulse");

    a_tick_clears: assert property (@(posedge i_clk) disable iff (!i_rst_n)
        i_commit && i_cmd.tick && !i_cmd.pulse |=> r_pulses == 16'd0)
        else $error("pulse count not cleared by a tick");

    a_duty_range: assert property (@(posedge i_clk) disable iff (!i_rst_n)
        r_duty <= DUTY_MAX)
        else $error("duty above full scale");

endmodule
